### src/dfe_pkg.sv
// ----------------------------------------------------------------------------
// dfe_pkg: shared types and constants of the delimited frame extractor
// Byte and length widths, delimiter reset codes, register indexes, the
// deframer phase encoding and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package dfe_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 1024;
  // payload counter holds 0 .. MAX_FRAME_BYTES
  localparam int unsigned CNT_W  = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 11;

  // configuration port
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END    = 2'd2;

  // delimiter codes after reset: '!', '&', '#'
  localparam logic [BYTE_W-1:0] ESCAPE_RST = 8'h21;
  localparam logic [BYTE_W-1:0] START_RST  = 8'h26;
  localparam logic [BYTE_W-1:0] END_RST    = 8'h23;

  typedef enum logic [3:0] {
    PH_HUNT    = 4'b0001,
    PH_ESC_OUT = 4'b0010,
    PH_FRAME   = 4'b0100,
    PH_ESC_IN  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              is_frame_end;
    logic [LEN_W-1:0]  frame_len;
    logic              overflow;
    logic              last;
  } result_t;

  // results written into the output queue in one cycle
  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t res0;
    result_t res1;
  } push_t;

endpackage

`default_nettype wire

### src/dfe_if.sv
// ----------------------------------------------------------------------------
// dfe_in_if / dfe_out_if: valid/ready channels of the frame extractor
// Byte input channel and result output channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfe_in_if;
  logic                       valid;
  logic                       ready;
  logic [dfe_pkg::BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface dfe_out_if;
  logic                       valid;
  logic                       ready;
  logic [dfe_pkg::BYTE_W-1:0] out_byte;
  logic                       is_frame_end;
  logic [dfe_pkg::LEN_W-1:0]  frame_len;
  logic                       overflow;
  logic                       last;

  modport source (output valid, output out_byte, output is_frame_end,
                  output frame_len, output overflow, output last, input ready);
  modport sink   (input valid, input out_byte, input is_frame_end,
                  input frame_len, input overflow, input last, output ready);
endinterface

`default_nettype wire

### src/dfe_core.sv
// ----------------------------------------------------------------------------
// dfe_core: deframing state machine
// Input byte register, delimiter registers and the per-byte phase logic
// that produces up to two results per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module dfe_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [dfe_pkg::BYTE_W-1:0]      in_byte,
  input  wire logic                            cfg_we,
  input  wire logic [dfe_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [dfe_pkg::BYTE_W-1:0]      cfg_wdata,
  input  wire logic                            room2,
  output dfe_pkg::push_t                       push
);

  logic                       vld_r;
  logic [dfe_pkg::BYTE_W-1:0] byte_r;
  logic [dfe_pkg::BYTE_W-1:0] esc_r, start_r, end_r;
  dfe_pkg::phase_t            phase_r, phase_nxt;
  logic [dfe_pkg::CNT_W-1:0]  cnt_r, cnt_nxt, cnt_a;
  logic                       ovf_r, ovf_nxt;
  logic                       fire;
  logic                       try_a, try_b, ok_a, ok_b, frame_end;
  logic [dfe_pkg::BYTE_W-1:0] byte_a;
  dfe_pkg::result_t           res_end, res_a, res_b;

  assign fire     = vld_r && room2;
  assign in_ready = !vld_r || fire;

  // input byte register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      vld_r <= 1'b1;
    end else if (fire) begin
      vld_r <= 1'b0;
    end
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
    end
  end

  // delimiter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r   <= dfe_pkg::ESCAPE_RST;
      start_r <= dfe_pkg::START_RST;
      end_r   <= dfe_pkg::END_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        dfe_pkg::REG_ESCAPE: esc_r   <= cfg_wdata;
        dfe_pkg::REG_START:  start_r <= cfg_wdata;
        dfe_pkg::REG_END:    end_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    try_a     = 1'b0;
    try_b     = 1'b0;
    frame_end = 1'b0;
    byte_a    = byte_r;
    if (fire) begin
      case (phase_r)
        dfe_pkg::PH_HUNT: begin
          if (byte_r == esc_r) phase_nxt = dfe_pkg::PH_ESC_OUT;
        end
        dfe_pkg::PH_ESC_OUT: begin
          if (byte_r == start_r) begin
            phase_nxt = dfe_pkg::PH_FRAME;
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
          end else begin
            phase_nxt = dfe_pkg::PH_HUNT;
          end
        end
        dfe_pkg::PH_FRAME: begin
          if (byte_r == esc_r) phase_nxt = dfe_pkg::PH_ESC_IN;
          else                 try_a     = 1'b1;
        end
        dfe_pkg::PH_ESC_IN: begin
          // end code wins over escape code when both are equal
          if (byte_r == end_r) begin
            frame_end = 1'b1;
            phase_nxt = dfe_pkg::PH_HUNT;
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
          end else if (byte_r == esc_r) begin
            try_a  = 1'b1;
            byte_a = esc_r;
          end else begin
            try_a     = 1'b1;
            try_b     = 1'b1;
            byte_a    = esc_r;
            phase_nxt = dfe_pkg::PH_FRAME;
          end
        end
        default: phase_nxt = dfe_pkg::PH_HUNT;
      endcase
    end
    // bytes past the frame limit are dropped and flagged
    ok_a  = try_a && (cnt_r < dfe_pkg::CNT_W'(dfe_pkg::MAX_FRAME_BYTES));
    cnt_a = cnt_r + dfe_pkg::CNT_W'(ok_a);
    ok_b  = try_b && (cnt_a < dfe_pkg::CNT_W'(dfe_pkg::MAX_FRAME_BYTES));
    if (try_a) begin
      cnt_nxt = cnt_a + dfe_pkg::CNT_W'(ok_b);
      ovf_nxt = ovf_r || !ok_a || (try_b && !ok_b);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= dfe_pkg::PH_HUNT;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_comb begin
    res_end              = '0;
    res_end.is_frame_end = 1'b1;
    res_end.frame_len    = dfe_pkg::LEN_W'(cnt_r);
    res_end.overflow     = ovf_r;
    res_end.last         = 1'b1;
    res_a                = '0;
    res_a.out_byte       = byte_a;
    res_a.last           = !ok_b;
    res_b                = '0;
    res_b.out_byte       = byte_r;
    res_b.last           = 1'b1;
    push.push0           = frame_end || ok_a;
    push.push1           = ok_a && ok_b;
    push.res0            = frame_end ? res_end : res_a;
    push.res1            = res_b;
  end

  property p_second_needs_first;
    @(posedge clk) disable iff (!rst_n) push.push1 |-> push.push0 && !push.res0.last;
  endproperty
  a_second_needs_first: assert property (p_second_needs_first)
    else $error("second result without an open first result");

  property p_single_is_last;
    @(posedge clk) disable iff (!rst_n) (push.push0 && !push.push1) |-> push.res0.last;
  endproperty
  a_single_is_last: assert property (p_single_is_last)
    else $error("lone result not marked last");

  property p_cnt_bound;
    @(posedge clk) disable iff (!rst_n)
      cnt_r <= dfe_pkg::CNT_W'(dfe_pkg::MAX_FRAME_BYTES);
  endproperty
  a_cnt_bound: assert property (p_cnt_bound)
    else $error("payload count beyond frame limit");

  property p_push_only_on_fire;
    @(posedge clk) disable iff (!rst_n) push.push0 |-> room2 && vld_r;
  endproperty
  a_push_only_on_fire: assert property (p_push_only_on_fire)
    else $error("result produced without queue room");

endmodule

`default_nettype wire

### src/dfe_result_fifo.sv
// ----------------------------------------------------------------------------
// dfe_result_fifo: result queue
// Four-entry register queue taking up to two results per cycle and
// presenting the head result on the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module dfe_result_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire dfe_pkg::push_t push,
  output logic                room2,
  output logic                out_valid,
  input  wire logic           out_ready,
  output dfe_pkg::result_t    out_res
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  dfe_pkg::result_t   mem_r [DEPTH];
  logic [PTR_W-1:0]   wp_r, rp_r, wp_1;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != '0);
  assign out_res   = mem_r[rp_r];
  assign room2     = (count_r <= CNT_W'(DEPTH - 2));
  assign wp_1      = wp_r + PTR_W'(1);

  always_comb begin
    count_nxt = count_r + CNT_W'(push.push0) + CNT_W'(push.push1) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_r + PTR_W'(push.push0) + PTR_W'(push.push1);
      rp_r    <= rp_r + PTR_W'(pop);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.push0) mem_r[wp_r] <= push.res0;
    if (push.push1) mem_r[wp_1] <= push.res1;
  end

  property p_no_overrun;
    @(posedge clk) disable iff (!rst_n) count_r <= CNT_W'(DEPTH);
  endproperty
  a_no_overrun: assert property (p_no_overrun)
    else $error("result queue overrun");

  property p_push_has_room;
    @(posedge clk) disable iff (!rst_n)
      push.push0 |-> count_r <= CNT_W'(DEPTH - 2);
  endproperty
  a_push_has_room: assert property (p_push_has_room)
    else $error("push into a queue without room for two");

  property p_count_tracks;
    @(posedge clk) disable iff (!rst_n)
      (!push.push0 && !pop) |=> count_r == $past(count_r);
  endproperty
  a_count_tracks: assert property (p_count_tracks)
    else $error("queue count moved without a transfer");

endmodule

`default_nettype wire

### src/delimited_frame_extractor.sv
// ----------------------------------------------------------------------------
// delimited_frame_extractor: two-byte delimiter deframer
// Takes one raw link byte per transfer on in_ch and returns payload bytes
// and frame-end records on out_ch.
//
// usage
//   - in_ch carries one byte per transfer; out_ch carries one result per
//     transfer: a payload byte, or a frame-end record with frame_len and
//     overflow; last marks the final result caused by one input byte
//   - a frame opens with (escape, start) and closes with (escape, end);
//     both pairs are stripped, an escape inside a frame is held until the
//     next byte shows whether it closes the frame
//   - bytes beyond the frame limit are dropped and reported by overflow
//   - cfg_we/cfg_idx/cfg_wdata write escape (0), start (1) and end (2)
//     codes; write only while the block is idle
// timing
//   - an input byte is registered in the core and its results are written
//     to the result queue before out_ch shows them; one byte per cycle
//     while out_ch is ready and each byte gives at most one result; a byte
//     that releases a held escape gives two results for the one output port
//   - if out_ch stalls, the four-entry result queue fills and in_ready
//     drops once fewer than two entries are free; nothing is lost
// reset
//   - rst_n (synchronous, low) clears the queue, returns to hunting and
//     restores the delimiter codes '!', '&' and '#'
// ----------------------------------------------------------------------------
`default_nettype none

module delimited_frame_extractor (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  dfe_in_if.sink                             in_ch,
  dfe_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [dfe_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [dfe_pkg::BYTE_W-1:0]    cfg_wdata
);

  dfe_pkg::push_t   push;     // results of the byte being processed
  logic             room2;    // queue can take two more results
  dfe_pkg::result_t head;     // result at the head of the queue

  // byte register and phase logic
  dfe_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_byte   (in_ch.in_byte),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .room2     (room2),
    .push      (push)
  );

  // result queue, decouples the output stall from byte intake
  dfe_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room2     (room2),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (head)
  );

  // unpack the head result onto the channel fields
  assign out_ch.out_byte     = head.out_byte;
  assign out_ch.is_frame_end = head.is_frame_end;
  assign out_ch.frame_len    = head.frame_len;
  assign out_ch.overflow     = head.overflow;
  assign out_ch.last         = head.last;

endmodule

`default_nettype wire

### bench/tb_delimited_frame_extractor.sv
// ----------------------------------------------------------------------------
// tb_delimited_frame_extractor: self-checking bench for the frame extractor
// Feeds link bytes through the input channel, predicts every payload and
// frame-end record in a behavioral deframer, and compares each output
// transfer field by field. Covers several delimiter settings, overflow of a
// full frame, random idling on both sides and a long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_delimited_frame_extractor;

  localparam int unsigned IDLE_PCT     = 12;       // idle chance per cycle, both sides
  localparam int unsigned HOLD_CYCLES  = 80;       // long output stall
  localparam int unsigned SETTLE_CYCLES = 8;       // pipeline slack after the last result
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned MAX_PRINTS   = 30;
  // index past the last register, must be ignored by the block
  localparam logic [dfe_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n;
  logic                          cfg_we;
  logic [dfe_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [dfe_pkg::BYTE_W-1:0]    cfg_wdata;

  dfe_in_if  in_ch();
  dfe_out_if out_ch();

  delimited_frame_extractor uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // link bytes waiting for the driver, results waiting for the monitor
  logic [dfe_pkg::BYTE_W-1:0] link_bytes[$];
  dfe_pkg::result_t           pending_results[$];

  // deframer shadow: delimiter codes and frame state
  logic [dfe_pkg::BYTE_W-1:0] esc_code, start_code, end_code;
  dfe_pkg::phase_t            frame_phase = dfe_pkg::PH_HUNT;
  int unsigned                kept_bytes;
  logic                       dropped_any = 1'b0;

  // pacing controls, written by the sequencer
  logic        steady;     // no idling on either side
  logic        hold_req;   // request one long output stall
  logic        hold_done;
  int unsigned hold_left;

  int unsigned mismatches;
  int unsigned bytes_sent;
  int unsigned results_seen;
  int unsigned frames_closed;
  int unsigned frames_overflowed;
  int unsigned cycle_count;

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------
  task automatic push_result(input logic [dfe_pkg::BYTE_W-1:0] b, input logic frame_end,
                             input logic [dfe_pkg::LEN_W-1:0] len, input logic ovf);
    dfe_pkg::result_t r;
    r.out_byte     = b;
    r.is_frame_end = frame_end;
    r.frame_len    = len;
    r.overflow     = ovf;
    r.last         = 1'b0;
    pending_results.push_back(r);
  endtask

  // a payload byte is kept until the frame is full, then only flagged
  task automatic keep_payload(input logic [dfe_pkg::BYTE_W-1:0] b);
    if (kept_bytes >= dfe_pkg::MAX_FRAME_BYTES) begin
      dropped_any = 1'b1;
    end else begin
      kept_bytes++;
      push_result(b, 1'b0, '0, 1'b0);
    end
  endtask

  task automatic deframe_byte(input logic [dfe_pkg::BYTE_W-1:0] b);
    int unsigned n_prior;
    n_prior = pending_results.size();
    case (frame_phase)
      dfe_pkg::PH_HUNT: begin
        if (b == esc_code) frame_phase = dfe_pkg::PH_ESC_OUT;
      end
      dfe_pkg::PH_ESC_OUT: begin
        // start code wins over escape when both match
        if (b == start_code) begin
          frame_phase = dfe_pkg::PH_FRAME;
          kept_bytes  = 0;
          dropped_any = 1'b0;
        end else begin
          frame_phase = dfe_pkg::PH_HUNT;
        end
      end
      dfe_pkg::PH_FRAME: begin
        if (b == esc_code) frame_phase = dfe_pkg::PH_ESC_IN;
        else keep_payload(b);
      end
      default: begin
        // held escape: end code tested before escape code
        if (b == end_code) begin
          push_result('0, 1'b1, dfe_pkg::LEN_W'(kept_bytes), dropped_any);
          frame_phase = dfe_pkg::PH_HUNT;
          kept_bytes  = 0;
          dropped_any = 1'b0;
        end else if (b == esc_code) begin
          keep_payload(esc_code);
        end else begin
          keep_payload(esc_code);
          keep_payload(b);
          frame_phase = dfe_pkg::PH_FRAME;
        end
      end
    endcase
    if (pending_results.size() > n_prior)
      pending_results[pending_results.size()-1].last = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // driver: offers queued bytes, predicts on each accepted transfer
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.in_byte <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        deframe_byte(in_ch.in_byte);
        bytes_sent++;
      end
      // load the next byte once the current one is gone or none is offered
      if (!in_ch.valid || in_ch.ready) begin
        if (link_bytes.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          in_ch.valid   <= 1'b1;
          in_ch.in_byte <= link_bytes.pop_front();
        end else begin
          in_ch.valid   <= 1'b0;
          in_ch.in_byte <= dfe_pkg::BYTE_W'($urandom);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // long output stall, counted here so the sender keeps offering meanwhile
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_PRINTS)
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // monitor: checks every output transfer against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    dfe_pkg::result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result byte %02h end %0b len %0d",
                                    out_ch.out_byte, out_ch.is_frame_end,
                                    out_ch.frame_len));
        end else begin
          want = pending_results.pop_front();
          if (out_ch.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, want %02h",
                                      out_ch.out_byte, want.out_byte));
          if (out_ch.is_frame_end !== want.is_frame_end)
            report_mismatch($sformatf("is_frame_end %0b, want %0b",
                                      out_ch.is_frame_end, want.is_frame_end));
          if (out_ch.frame_len !== want.frame_len)
            report_mismatch($sformatf("frame_len %0d, want %0d",
                                      out_ch.frame_len, want.frame_len));
          if (out_ch.overflow !== want.overflow)
            report_mismatch($sformatf("overflow %0b, want %0b",
                                      out_ch.overflow, want.overflow));
          if (out_ch.last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b",
                                      out_ch.last, want.last));
          if (want.is_frame_end) frames_closed++;
          if (want.is_frame_end && want.overflow) frames_overflowed++;
        end
      end
      out_ch.ready <= (hold_left == 0) && (steady || $urandom_range(99) >= IDLE_PCT);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_byte(input logic [dfe_pkg::BYTE_W-1:0] b);
    link_bytes.push_back(b);
  endtask

  function automatic logic [dfe_pkg::BYTE_W-1:0] rand_byte();
    return dfe_pkg::BYTE_W'($urandom);
  endfunction

  // byte that neither escapes nor closes under the current codes
  function automatic logic [dfe_pkg::BYTE_W-1:0] plain_byte();
    logic [dfe_pkg::BYTE_W-1:0] b;
    b = rand_byte();
    while (b == esc_code || b == end_code) b = rand_byte();
    return b;
  endfunction

  // opening pair, payload with held escapes mixed in, optional closing pair
  task automatic add_frame(input int unsigned len, input bit closed);
    int unsigned pick;
    add_byte(esc_code);
    add_byte(start_code);
    for (int unsigned i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        // escape then a random byte, released together unless it is the end or escape code
        add_byte(esc_code);
        add_byte(rand_byte());
      end else if (pick < 16) begin
        // repeated escape inside the frame
        add_byte(esc_code);
        add_byte(esc_code);
      end else begin
        add_byte(rand_byte());
      end
    end
    if (closed) begin
      add_byte(esc_code);
      add_byte(end_code);
    end
  endtask

  // mostly well-formed frames, the rest line noise, broken pairs and frames left open
  task automatic add_traffic(input int unsigned n_bytes);
    int unsigned goal;
    int unsigned pick;
    logic [dfe_pkg::BYTE_W-1:0] b;
    goal = link_bytes.size() + n_bytes;
    while (link_bytes.size() < goal) begin
      pick = $urandom_range(99);
      if (pick < 72) begin
        add_frame(($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(12), 1'b1);
      end else if (pick < 82) begin
        repeat ($urandom_range(1, 3)) add_byte(rand_byte());
      end else if (pick < 90) begin
        // broken start pair
        b = rand_byte();
        while (b == start_code) b = rand_byte();
        add_byte(esc_code);
        add_byte(($urandom_range(1) == 0) ? esc_code : b);
      end else if (pick < 95) begin
        // escape, escape, start: second escape drops back to the hunt
        add_byte(esc_code);
        add_byte(esc_code);
        add_byte(start_code);
      end else begin
        // frame left open, the next opening pair lands in its payload
        add_frame($urandom_range(6), 1'b0);
      end
    end
  endtask

  // frame past the size limit: ends with length at the limit and overflow set
  task automatic add_full_frame();
    add_byte(esc_code);
    add_byte(start_code);
    repeat (dfe_pkg::MAX_FRAME_BYTES - 4) add_byte(plain_byte());
    add_byte(esc_code);                 // escape plus byte, two kept
    add_byte(plain_byte());
    add_byte(plain_byte());             // one below the limit
    add_byte(esc_code);                 // escape kept, byte after it dropped
    add_byte(plain_byte());
    repeat (3) add_byte(plain_byte());  // dropped
    add_byte(esc_code);                 // repeated escape while full
    add_byte(esc_code);
    add_byte(end_code);                 // held escape closes the frame
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (link_bytes.size() != 0 || in_ch.valid || pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // a held escape is released with the escape code in force, so never leave
  // one pending across a code change
  task automatic settle();
    wait_idle();
    if (frame_phase == dfe_pkg::PH_ESC_IN) begin
      add_byte(end_code);
      wait_idle();
    end
  endtask

  task automatic write_reg(input logic [dfe_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dfe_pkg::BYTE_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      dfe_pkg::REG_ESCAPE: esc_code   = val;
      dfe_pkg::REG_START:  start_code = val;
      dfe_pkg::REG_END:    end_code   = val;
      default: ;
    endcase
  endtask

  task automatic set_codes(input logic [dfe_pkg::BYTE_W-1:0] e,
                           input logic [dfe_pkg::BYTE_W-1:0] s,
                           input logic [dfe_pkg::BYTE_W-1:0] n);
    write_reg(dfe_pkg::REG_ESCAPE, e);
    write_reg(dfe_pkg::REG_START, s);
    write_reg(dfe_pkg::REG_END, n);
  endtask

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = dfe_pkg::REG_ESCAPE;
    cfg_wdata     = '0;
    steady        = 1'b0;
    hold_req      = 1'b0;
    esc_code      = dfe_pkg::ESCAPE_RST;
    start_code    = dfe_pkg::START_RST;
    end_code      = dfe_pkg::END_RST;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset codes
    add_byte(8'h00);                     // noise at both extremes
    add_byte(8'hFF);
    add_byte(esc_code);                  // broken start pair on escape itself
    add_byte(esc_code);
    add_byte(start_code);
    add_byte(esc_code);                  // opening pair
    add_byte(start_code);
    add_byte(8'h00);                     // payload extremes
    add_byte(8'hFF);
    add_byte(esc_code);                  // repeated escape
    add_byte(esc_code);
    add_byte(8'h41);                     // held escape released with next byte
    add_byte(esc_code);                  // closing pair
    add_byte(end_code);
    add_byte(esc_code);                  // empty frame
    add_byte(start_code);
    add_byte(esc_code);
    add_byte(end_code);
    add_byte(esc_code);                  // closing pair outside a frame
    add_byte(end_code);
    settle();

    // reset codes, long output stall while the sender keeps offering
    add_traffic(120);
    @(posedge clk);
    hold_req <= 1'b1;
    add_full_frame();
    settle();

    // extreme codes, no idling on either side
    set_codes(8'h00, 8'hFF, 8'h80);
    steady <= 1'b1;
    add_traffic(120);
    settle();
    steady <= 1'b0;

    // end code equal to escape code
    set_codes(8'hFF, 8'h00, 8'hFF);
    add_traffic(100);
    settle();

    // all three codes equal
    set_codes(8'h7E, 8'h7E, 8'h7E);
    add_traffic(100);
    settle();

    // random codes
    set_codes(rand_byte(), rand_byte(), rand_byte());
    add_traffic(100);
    settle();

    // back to reset codes, then a write to an unused index must change nothing;
    // sender pauses halfway until every result has come back
    set_codes(dfe_pkg::ESCAPE_RST, dfe_pkg::START_RST, dfe_pkg::END_RST);
    write_reg(REG_UNUSED, 8'hA5);
    add_traffic(40);
    wait_idle();
    add_traffic(40);
    settle();

    $display("sent %0d link bytes under six delimiter settings; checked %0d results",
             bytes_sent, results_seen);
    $display("frames closed: %0d, of which %0d overflowed", frames_closed,
             frames_overflowed);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
src/dfe_pkg.sv
src/dfe_if.sv
src/dfe_core.sv
src/dfe_result_fifo.sv
src/delimited_frame_extractor.sv
bench/tb_delimited_frame_extractor.sv
